[rtl/mbet_pkg.sv]
// Shared types, constants and helper functions of the escape-time pixel engine.
package mbet_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int COORD_BITS = 12;
    localparam int WORD_BITS  = 32;
    localparam int PROD_BITS  = 2 * WORD_BITS;
    localparam int COUNT_BITS = 16;
    localparam int COLOR_BITS = 8;
    localparam int FIELD_BITS = 12;

    localparam int IN_DATA_BITS  = 24;
    localparam int OUT_DATA_BITS = 40;
    localparam int CFG_IDX_BITS  = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] REG_LEFT  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TOP   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_XSTEP = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_YSTEP = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_LIMIT = 3'd4;

    localparam logic signed [WORD_BITS-1:0] LEFT_RESET  = -32'sd536870912;
    localparam logic signed [WORD_BITS-1:0] TOP_RESET   = 32'sd301989888;
    localparam logic [COUNT_BITS-1:0]       LIMIT_RESET = 16'd768;

    // |z|^2 is compared as the model does: (mag >> FRAC_BITS) >= 4 << FRAC_BITS.
    localparam logic [PROD_BITS-1:0] ESC_BOUND = 64'd4 << FRAC_BITS;

    // floor(x / 3) for 16-bit x is (x * 43691) >> 17.
    localparam logic [17:0] THIRD_MUL   = 18'd43691;
    localparam int          THIRD_SHIFT = 17;

    localparam logic signed [PROD_BITS-1:0] WORD_MAX = 64'sd2147483647;
    localparam logic signed [PROD_BITS-1:0] WORD_MIN = -64'sd2147483648;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic word_t sat_word(input prod_t v);
        word_t r;
        if (v > WORD_MAX) begin
            r = WORD_MAX[WORD_BITS-1:0];
        end else if (v < WORD_MIN) begin
            r = WORD_MIN[WORD_BITS-1:0];
        end else begin
            r = v[WORD_BITS-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/mbet_mul.sv]
// Shared signed 32 x 32 multiplier with a registered 64-bit product.
module mbet_mul (
    input  logic          aclk,
    input  mbet_pkg::word_t op_a,
    input  mbet_pkg::word_t op_b,
    output mbet_pkg::prod_t product
);

    mbet_pkg::prod_t prod_reg;
    mbet_pkg::prod_t prod_next;

    always_comb begin
        prod_next = mbet_pkg::prod_t'(op_a) * mbet_pkg::prod_t'(op_b);
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign product = prod_reg;

endmodule

[rtl/mandelbrot_escape_time_pixel.sv]
// Top level of the escape-time pixel engine: sequencer, iterate registers and ports.
//
// Usage. Each item on the s_ channel is one pixel (column, row). The engine
// forms c = (left_edge + col*x_step) + i*(top_edge + row*y_step) in signed
// Q4.28, iterates z = z*z + c from zero while |z|^2 < 4 and the count is
// below iteration_limit, and returns one item on the m_ channel with the
// count and three color bytes.
// All products go through one shared 32 x 32 multiplier with a registered
// output. Setup does two multiplies for c; each iteration does zr*zr,
// zi*zi, zr*zi, then the update and escape test. A pixel that stops on the
// limit goes from the limit test in ST_SQ_R to ST_FINISH, which loads the
// result; one that escapes goes there from the escape test in ST_UPDATE.
// s_tready is high only in ST_IDLE, so a new pixel is taken only after the
// last one has left ST_FINISH. The result sits in an output register, so
// the next pixel is taken while it still waits for m_tready; a second
// result waits in the sequencer until the register frees up. Configuration
// goes through the cfg_ channel (always ready) and is to be written by the
// user only while the engine is idle; the block does not enforce this. A
// synchronous active-low reset restores the default view and a limit of
// 768 and empties the output register.
module mandelbrot_escape_time_pixel (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // Fields from bit 0 up: pixel_col[11:0], pixel_row[23:12].
    input  logic [mbet_pkg::IN_DATA_BITS-1:0]    s_tdata,

    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // Fields from bit 0 up: escape_count[15:0], red_byte[23:16],
    // green_byte[31:24], blue_byte[39:32].
    output logic [mbet_pkg::OUT_DATA_BITS-1:0]   m_tdata,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mbet_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [mbet_pkg::WORD_BITS-1:0]       cfg_data
);

    // One-hot sequencer states.
    typedef enum logic [8:0] {
        ST_IDLE    = 9'b0_0000_0001,
        ST_MUL_X   = 9'b0_0000_0010,
        ST_LOAD_CR = 9'b0_0000_0100,
        ST_LOAD_CI = 9'b0_0000_1000,
        ST_SQ_R    = 9'b0_0001_0000,
        ST_SQ_I    = 9'b0_0010_0000,
        ST_CROSS   = 9'b0_0100_0000,
        ST_UPDATE  = 9'b0_1000_0000,
        ST_FINISH  = 9'b1_0000_0000
    } state_t;

    localparam int CB = mbet_pkg::COUNT_BITS;
    localparam int KB = mbet_pkg::COORD_BITS;
    localparam int WB = mbet_pkg::WORD_BITS;

    state_t state_reg, state_next;

    // Configuration registers.
    mbet_pkg::word_t left_reg, left_next;
    mbet_pkg::word_t top_reg, top_next;
    mbet_pkg::word_t xstep_reg, xstep_next;
    mbet_pkg::word_t ystep_reg, ystep_next;
    logic [CB-1:0]   limit_reg, limit_next;

    // Per-pixel working registers.
    logic [KB-1:0]   col_reg, col_next;
    logic [KB-1:0]   row_reg, row_next;
    mbet_pkg::word_t cr_reg, cr_next;
    mbet_pkg::word_t ci_reg, ci_next;
    mbet_pkg::word_t zr_reg, zr_next;
    mbet_pkg::word_t zi_reg, zi_next;
    mbet_pkg::prod_t rr_reg, rr_next;
    mbet_pkg::prod_t ii_reg, ii_next;
    logic [CB-1:0]   count_reg, count_next;
    logic [CB-1:0]   third_reg, third_next;

    // Output register.
    logic                               out_valid_reg, out_valid_next;
    logic [mbet_pkg::OUT_DATA_BITS-1:0] out_data_reg, out_data_next;

    // Shared multiplier.
    mbet_pkg::word_t op_a, op_b;
    mbet_pkg::prod_t product;

    // Datapath helpers.
    logic [mbet_pkg::PROD_BITS-1:0] mag;
    logic                           escaped;
    mbet_pkg::prod_t                re_sum, im_sum;
    logic [33:0]                    third_prod;
    logic [CB-1:0]                  half_limit;
    logic                           s_fire, out_free;

    // Low byte of |a - b| for two unsigned counts.
    function automatic logic [mbet_pkg::COLOR_BITS-1:0] abs_byte(
        input logic [mbet_pkg::COUNT_BITS-1:0] a,
        input logic [mbet_pkg::COUNT_BITS-1:0] b
    );
        logic [mbet_pkg::COUNT_BITS-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d[mbet_pkg::COLOR_BITS-1:0];
    endfunction

    mbet_mul u_mul (
        .aclk    (aclk),
        .op_a    (op_a),
        .op_b    (op_b),
        .product (product)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign out_free  = !out_valid_reg || m_tready;

    // The squares are never negative, so their sum fits as unsigned.
    assign mag     = rr_reg + ii_reg;
    assign escaped = (mag >> mbet_pkg::FRAC_BITS) >= mbet_pkg::ESC_BOUND;
    assign re_sum  = ((rr_reg - ii_reg) >>> mbet_pkg::FRAC_BITS)
                     + mbet_pkg::prod_t'(cr_reg);
    assign im_sum  = (product >>> (mbet_pkg::FRAC_BITS - 1))
                     + mbet_pkg::prod_t'(ci_reg);

    assign third_prod = 34'(limit_reg) * 34'(mbet_pkg::THIRD_MUL);
    assign half_limit = limit_reg >> 1;

    // Multiplier operand selection.
    always_comb begin
        op_a = zr_reg;
        op_b = zi_reg;
        unique case (state_reg)
            ST_MUL_X: begin
                op_a = mbet_pkg::word_t'({{(WB-KB){1'b0}}, col_reg});
                op_b = xstep_reg;
            end
            ST_LOAD_CR: begin
                op_a = mbet_pkg::word_t'({{(WB-KB){1'b0}}, row_reg});
                op_b = ystep_reg;
            end
            ST_SQ_R: begin
                op_a = zr_reg;
                op_b = zr_reg;
            end
            ST_SQ_I: begin
                op_a = zi_reg;
                op_b = zi_reg;
            end
            default: begin
                op_a = zr_reg;
                op_b = zi_reg;
            end
        endcase
    end

    // Configuration writes.
    always_comb begin
        left_next  = left_reg;
        top_next   = top_reg;
        xstep_next = xstep_reg;
        ystep_next = ystep_reg;
        limit_next = limit_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                mbet_pkg::REG_LEFT:  left_next  = cfg_data;
                mbet_pkg::REG_TOP:   top_next   = cfg_data;
                mbet_pkg::REG_XSTEP: xstep_next = cfg_data;
                mbet_pkg::REG_YSTEP: ystep_next = cfg_data;
                mbet_pkg::REG_LIMIT: limit_next = cfg_data[CB-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer and iterate datapath.
    always_comb begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        cr_next        = cr_reg;
        ci_next        = ci_reg;
        zr_next        = zr_reg;
        zi_next        = zi_reg;
        rr_next        = rr_reg;
        ii_next        = ii_reg;
        count_next     = count_reg;
        third_next     = third_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    col_next   = s_tdata[KB-1:0];
                    row_next   = s_tdata[mbet_pkg::FIELD_BITS +: KB];
                    zr_next    = '0;
                    zi_next    = '0;
                    count_next = '0;
                    state_next = ST_MUL_X;
                end
            end
            ST_MUL_X: begin
                state_next = ST_LOAD_CR;
            end
            ST_LOAD_CR: begin
                cr_next    = mbet_pkg::sat_word(mbet_pkg::prod_t'(left_reg) + product);
                third_next = third_prod[mbet_pkg::THIRD_SHIFT +: CB];
                state_next = ST_LOAD_CI;
            end
            ST_LOAD_CI: begin
                ci_next    = mbet_pkg::sat_word(mbet_pkg::prod_t'(top_reg) + product);
                state_next = ST_SQ_R;
            end
            ST_SQ_R: begin
                // The limit test comes before the escape test, as a zero
                // limit must give no iteration at all.
                if (count_reg >= limit_reg) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_SQ_I;
                end
            end
            ST_SQ_I: begin
                rr_next    = product;
                state_next = ST_CROSS;
            end
            ST_CROSS: begin
                ii_next    = product;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (escaped) begin
                    state_next = ST_FINISH;
                end else begin
                    zr_next    = mbet_pkg::sat_word(re_sum);
                    zi_next    = mbet_pkg::sat_word(im_sum);
                    count_next = count_reg + 1'b1;
                    state_next = ST_SQ_R;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {abs_byte(count_reg, third_reg),
                                      abs_byte(count_reg, half_limit),
                                      abs_byte(count_reg, limit_reg),
                                      count_reg};
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            left_reg      <= mbet_pkg::LEFT_RESET;
            top_reg       <= mbet_pkg::TOP_RESET;
            xstep_reg     <= '0;
            ystep_reg     <= '0;
            limit_reg     <= mbet_pkg::LIMIT_RESET;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            left_reg      <= left_next;
            top_reg       <= top_next;
            xstep_reg     <= xstep_next;
            ystep_reg     <= ystep_next;
            limit_reg     <= limit_next;
        end
    end

    always_ff @(posedge aclk) begin
        col_reg      <= col_next;
        row_reg      <= row_next;
        cr_reg       <= cr_next;
        ci_reg       <= ci_next;
        zr_reg       <= zr_next;
        zi_reg       <= zi_next;
        rr_reg       <= rr_next;
        ii_reg       <= ii_next;
        count_reg    <= count_next;
        third_reg    <= third_next;
        out_data_reg <= out_data_next;
    end

endmodule

[sim/testbench.sv]
// Testbench for the escape-time pixel engine: directed table plus random pixels checked by a predictor.
`timescale 1ns / 1ps

module testbench;

    import mbet_pkg::*;

    // One result item as it travels on m_tdata, lowest field in the lowest bits.
    typedef struct packed {
        logic [7:0]  blue_byte;
        logic [7:0]  green_byte;
        logic [7:0]  red_byte;
        logic [15:0] escape_count;
    } pixel_result_t;

    // One row of the directed table. A row either writes a register or sends a
    // pixel. Pixel rows whose result is obvious carry it typed in; the others
    // are checked against the predictor.
    typedef struct packed {
        bit            is_write;
        logic [2:0]    reg_index;
        logic [31:0]   reg_value;
        logic [11:0]   col;
        logic [11:0]   row;
        bit            typed;
        pixel_result_t result;
    } stim_row_t;

    // |z|^2 at or above 4.0, with the squares carrying 2*FRAC_BITS fraction bits.
    localparam longint unsigned ESCAPE_MAG = 64'd4 << FRAC_BITS;
    // Length of the long receiver hold-off that backs the engine up.
    localparam int HOLD_CYCLES = 4000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // Predictor copy of the view registers.
    longint      view_left;
    longint      view_top;
    longint      view_col_step;
    longint      view_row_step;
    int unsigned iter_limit;

    pixel_result_t pending_pixels[$];
    stim_row_t     directed_rows[$];
    pixel_result_t seen_result;
    pixel_result_t want_result;
    int            mismatch_count = 0;

    // Idling controls, set per phase by the stimulus process.
    int send_idle_pct = 0;
    int stall_pct = 0;
    // Each increment asks the receiver for one long hold-off.
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;

    mandelbrot_escape_time_pixel dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 20 ns clock period.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Clamp an exact value to the signed 32-bit word range.
    function automatic longint clamp_word(input longint v);
        if (v > WORD_MAX) begin
            return WORD_MAX;
        end
        if (v < WORD_MIN) begin
            return WORD_MIN;
        end
        return v;
    endfunction

    // Low byte of the distance between two counts.
    function automatic logic [7:0] color_dist(input int unsigned a, input int unsigned b);
        int unsigned d;
        d = (a > b) ? a - b : b - a;
        return d[7:0];
    endfunction

    // Escape-time result of one pixel under the current view registers.
    function automatic pixel_result_t escape_time_of(input logic [11:0] col,
                                                      input logic [11:0] row);
        longint          col_v;
        longint          row_v;
        longint          cr;
        longint          ci;
        longint          zr;
        longint          zi;
        longint          rr;
        longint          ii;
        longint          nr;
        longint          ni;
        longint unsigned mag;
        int unsigned     n;
        bit              escaped;
        pixel_result_t   res;
        col_v = longint'(col);
        row_v = longint'(row);
        cr = clamp_word(view_left + col_v * view_col_step);
        ci = clamp_word(view_top + row_v * view_row_step);
        zr = 0;
        zi = 0;
        n = 0;
        escaped = 1'b0;
        while (!escaped && n < iter_limit) begin
            rr = zr * zr;
            ii = zi * zi;
            mag = rr + ii;
            if ((mag >> FRAC_BITS) >= ESCAPE_MAG) begin
                escaped = 1'b1;
            end else begin
                // Arithmetic shifts round toward minus infinity, as the engine does.
                nr = clamp_word(((rr - ii) >>> FRAC_BITS) + cr);
                ni = clamp_word(((zr * zi) >>> (FRAC_BITS - 1)) + ci);
                zr = nr;
                zi = ni;
                n++;
            end
        end
        res.escape_count = n[15:0];
        res.red_byte = color_dist(n, iter_limit);
        res.green_byte = color_dist(n, iter_limit / 2);
        res.blue_byte = color_dist(n, iter_limit / 3);
        return res;
    endfunction

    function automatic stim_row_t cfg_row(input logic [2:0] idx, input logic [31:0] value);
        stim_row_t r;
        r = '0;
        r.is_write = 1'b1;
        r.reg_index = idx;
        r.reg_value = value;
        return r;
    endfunction

    function automatic stim_row_t pixel_row(input logic [11:0] col, input logic [11:0] row);
        stim_row_t r;
        r = '0;
        r.col = col;
        r.row = row;
        return r;
    endfunction

    function automatic stim_row_t typed_row(input logic [11:0] col, input logic [11:0] row,
                                            input logic [15:0] count, input logic [7:0] red,
                                            input logic [7:0] green, input logic [7:0] blue);
        stim_row_t r;
        r = pixel_row(col, row);
        r.typed = 1'b1;
        r.result.escape_count = count;
        r.result.red_byte = red;
        r.result.green_byte = green;
        r.result.blue_byte = blue;
        return r;
    endfunction

    // Append one row to the end of the directed table.
    function automatic void add_row(input stim_row_t r);
        directed_rows = {directed_rows, r};
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        $display("%0t: wrong %s, got %0d, expected %0d", $time, what, got_v, want_v);
        mismatch_count++;
    endtask

    // Write one register through the configuration channel and mirror it in the
    // predictor. Returns on the edge after the write, with cfg_valid low again.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        logic signed [31:0] word;
        word = value;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_LEFT: begin
                view_left = longint'(word);
            end
            REG_TOP: begin
                view_top = longint'(word);
            end
            REG_XSTEP: begin
                view_col_step = longint'(word);
            end
            REG_YSTEP: begin
                view_row_step = longint'(word);
            end
            REG_LIMIT: begin
                iter_limit = {16'd0, value[15:0]};
            end
            default: begin
            end
        endcase
    endtask

    // Offer one pixel, with random idle cycles in front of it, and queue its
    // expected result once the engine has accepted it. Returns at the accepting
    // edge with s_tvalid still high.
    task automatic send_pixel(input logic [11:0] col, input logic [11:0] row,
                              input pixel_result_t want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {row, col};
        do @(posedge aclk); while (!s_tready);
        pending_pixels = {pending_pixels, want};
    endtask

    // Stop offering pixels and wait until every queued result has come back,
    // so that the engine is idle and registers may be written.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // Pick a view. The wide one spans most of the set across the full column
    // and row range; the zoomed one sits on the boundary near -0.75, where
    // counts vary a lot from pixel to pixel.
    task automatic set_view(input bit zoomed);
        longint left_v;
        longint top_v;
        longint dx;
        longint dy;
        if (!zoomed) begin
            left_v = -64'sd671088640 + longint'($urandom_range(0, 268435456));
            top_v = 64'sd134217728 + longint'($urandom_range(0, 268435456));
            dx = longint'($urandom_range(49152, 262144));
            dy = -longint'($urandom_range(49152, 196608));
        end else begin
            left_v = -64'sd234881024 + longint'($urandom_range(0, 67108864));
            top_v = longint'($urandom_range(0, 33554432));
            dx = longint'($urandom_range(0, 8192)) - 64'sd4096;
            dy = longint'($urandom_range(0, 8192)) - 64'sd4096;
        end
        write_reg(REG_LEFT, left_v[31:0]);
        write_reg(REG_TOP, top_v[31:0]);
        write_reg(REG_XSTEP, dx[31:0]);
        write_reg(REG_YSTEP, dy[31:0]);
    endtask

    // One random phase: a new view and limit, an idling style, then a batch of
    // random pixels. Limits stay small in most phases since every iteration
    // costs the engine three shared multiplies; one phase runs the default limit of 768.
    task automatic run_phase(input int ph);
        int          n_items;
        int          i;
        logic [15:0] lim;
        logic [11:0] col;
        logic [11:0] row;
        case (ph % 4)
            0: begin
                send_idle_pct = 0;
                stall_pct = 0;
            end
            1: begin
                send_idle_pct = 45;
                stall_pct = 0;
            end
            2: begin
                send_idle_pct = 0;
                stall_pct = 45;
            end
            default: begin
                send_idle_pct = 34;
                stall_pct = 34;
            end
        endcase
        case (ph)
            2, 5, 7: begin
                set_view(1'b1);
            end
            3: begin
                // Any register value at all; most points land far outside and
                // their coordinates saturate.
                write_reg(REG_LEFT, $urandom());
                write_reg(REG_TOP, $urandom());
                write_reg(REG_XSTEP, $urandom());
                write_reg(REG_YSTEP, $urandom());
            end
            default: begin
                set_view(1'b0);
            end
        endcase
        case (ph)
            1: lim = 16'($urandom_range(1, 32));
            2: lim = 16'($urandom_range(16, 64));
            3: lim = 16'($urandom_range(1, 255));
            4: lim = LIMIT_RESET;
            5: lim = 16'($urandom_range(1, 48));
            default: lim = 16'($urandom_range(1, 64));
        endcase
        write_reg(REG_LIMIT, {16'd0, lim});
        // In the first phase the receiver holds off for a long stretch while
        // pixels keep coming, so the engine fills up and drops s_tready.
        if (ph == 0) begin
            hold_requests++;
        end
        n_items = (ph == 4) ? 20 : 95;
        for (i = 0; i < n_items; i++) begin
            col = 12'($urandom_range(0, 4095));
            row = 12'($urandom_range(0, 4095));
            send_pixel(col, row, escape_time_of(col, row));
        end
        wait_drained();
    endtask

    // Receiver: random stalls at the phase's rate, plus the long hold-off,
    // which it counts down itself.
    always @(posedge aclk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Every accepted result is compared with the oldest queued expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_result = m_tdata;
            if (pending_pixels.size() == 0) begin
                report_mismatch("result with nothing pending",
                                int'(seen_result.escape_count), 0);
            end else begin
                want_result = pending_pixels.pop_front();
                if (seen_result.escape_count != want_result.escape_count) begin
                    report_mismatch("escape_count", int'(seen_result.escape_count),
                                    int'(want_result.escape_count));
                end
                if (seen_result.red_byte != want_result.red_byte) begin
                    report_mismatch("red_byte", int'(seen_result.red_byte),
                                    int'(want_result.red_byte));
                end
                if (seen_result.green_byte != want_result.green_byte) begin
                    report_mismatch("green_byte", int'(seen_result.green_byte),
                                    int'(want_result.green_byte));
                end
                if (seen_result.blue_byte != want_result.blue_byte) begin
                    report_mismatch("blue_byte", int'(seen_result.blue_byte),
                                    int'(want_result.blue_byte));
                end
            end
        end
    end

    initial begin : stimulus
        int            k;
        int            ph;
        stim_row_t     r;
        pixel_result_t want;

        // Right after reset the view is -2.0 + 1.125i for every pixel, which
        // leaves the radius on the first iteration: count 1 against limit 768.
        add_row(typed_row(12'd0, 12'd0, 16'd1, 8'hFF, 8'h7F, 8'hFF));
        add_row(typed_row(12'd4095, 12'd4095, 16'd1, 8'hFF, 8'h7F, 8'hFF));
        // The origin with the smallest limit stops on the limit after one step.
        add_row(cfg_row(REG_LEFT, 32'h0000_0000));
        add_row(cfg_row(REG_TOP, 32'h0000_0000));
        add_row(cfg_row(REG_XSTEP, 32'h0000_0000));
        add_row(cfg_row(REG_YSTEP, 32'h0000_0000));
        add_row(cfg_row(REG_LIMIT, 32'd1));
        add_row(typed_row(12'd0, 12'd0, 16'd1, 8'h00, 8'h01, 8'h01));
        add_row(typed_row(12'd4095, 12'd4095, 16'd1, 8'h00, 8'h01, 8'h01));
        // The origin never escapes, so the largest limit is reached in full.
        add_row(cfg_row(REG_LIMIT, 32'd65535));
        add_row(typed_row(12'hAAA, 12'h555, 16'hFFFF, 8'h00, 8'h00, 8'hAA));
        // Largest positive corner of the plane.
        add_row(cfg_row(REG_LEFT, 32'h7FFF_FFFF));
        add_row(cfg_row(REG_TOP, 32'h7FFF_FFFF));
        add_row(typed_row(12'd0, 12'd0, 16'd1, 8'hFE, 8'hFE, 8'h54));
        // Most negative edges and steps: the point saturates at the corner.
        add_row(cfg_row(REG_LEFT, 32'h8000_0000));
        add_row(cfg_row(REG_TOP, 32'h8000_0000));
        add_row(cfg_row(REG_XSTEP, 32'h8000_0000));
        add_row(cfg_row(REG_YSTEP, 32'h8000_0000));
        add_row(typed_row(12'd4095, 12'd4095, 16'd1, 8'hFE, 8'hFE, 8'h54));
        add_row(typed_row(12'd1, 12'd1, 16'd1, 8'hFE, 8'hFE, 8'h54));
        // Largest positive steps: one coordinate saturates high; the other is zero
        // for the first pixel and cancels to just below zero for the second.
        add_row(cfg_row(REG_XSTEP, 32'h7FFF_FFFF));
        add_row(cfg_row(REG_YSTEP, 32'h7FFF_FFFF));
        add_row(cfg_row(REG_TOP, 32'h0000_0000));
        add_row(cfg_row(REG_LIMIT, 32'd100));
        add_row(pixel_row(12'd4095, 12'd0));
        add_row(pixel_row(12'd1, 12'd4095));
        // c = -2 exactly puts |z|^2 right on 4.0, which counts as escaped.
        add_row(cfg_row(REG_LEFT, 32'hE000_0000));
        add_row(cfg_row(REG_XSTEP, 32'h0000_0000));
        add_row(cfg_row(REG_YSTEP, 32'h0000_0000));
        add_row(pixel_row(12'd5, 12'd5));
        // The cusp at 0.25 creeps toward its fixed point and runs to the limit.
        add_row(cfg_row(REG_LEFT, 32'h0400_0000));
        add_row(cfg_row(REG_LIMIT, 32'd300));
        add_row(pixel_row(12'd0, 12'd0));
        // Near -0.75 with steps of one LSB and a negative imaginary part, so
        // the products are negative and floor rounding matters.
        add_row(cfg_row(REG_LEFT, 32'hF400_0000));
        add_row(cfg_row(REG_XSTEP, 32'h0000_0001));
        add_row(cfg_row(REG_YSTEP, 32'hFFFF_FFFF));
        add_row(cfg_row(REG_LIMIT, 32'd200));
        add_row(pixel_row(12'd4095, 12'd4095));
        add_row(pixel_row(12'd1, 12'd4094));

        // Predictor starts from the reset view.
        view_left = longint'(LEFT_RESET);
        view_top = longint'(TOP_RESET);
        view_col_step = 0;
        view_row_step = 0;
        iter_limit = {16'd0, LIMIT_RESET};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (k = 0; k < directed_rows.size(); k++) begin
            r = directed_rows[k];
            if (r.is_write) begin
                wait_drained();
                write_reg(r.reg_index, r.reg_value);
            end else begin
                want = r.typed ? r.result : escape_time_of(r.col, r.row);
                send_pixel(r.col, r.row, want);
            end
        end
        wait_drained();

        for (ph = 0; ph < 8; ph++) begin
            run_phase(ph);
        end

        // Nothing is pending; give the engine one more full pixel time in case
        // it sends something it should not.
        repeat (4 * iter_limit + 10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // The slowest correct run is dominated by the pixel that runs 65535
    // iterations and the phase at limit 768; the 100 ms timeout is several
    // times the whole run.
    initial begin
        #100_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
rtl/mbet_pkg.sv
rtl/mbet_mul.sv
rtl/mandelbrot_escape_time_pixel.sv
sim/testbench.sv
